>>> rtl/htbl_pkg.sv
// Package for the handle table engine: sizes, codes, queue item and slot types.
// Used by every module of the block and by its checker; depends on nothing.

package htbl_pkg;

   localparam int SLOT_COUNT     = 64;
   localparam int OBJECT_ID_BITS = 16;
   localparam int SLOT_BITS      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   localparam int HANDLE_W  = 32;
   localparam int OBJECT_W  = 16;
   localparam int MASK_W    = 32;
   localparam int LOW_RIGHTS_W = 24;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 56;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam int QDEPTH     = 2;
   localparam int QPTR_BITS  = 1;
   localparam int QCNT_BITS  = 2;

   localparam logic [HANDLE_W-1:0] PSEUDO_THREAD  = 32'hFFFF_FFFE;
   localparam logic [HANDLE_W-1:0] PSEUDO_PROCESS = 32'hFFFF_FFFF;

   localparam int BIT_MAX_ALLOWED = 25;
   localparam int BIT_GEN_ALL     = 28;
   localparam int BIT_GEN_WRITE   = 30;
   localparam int BIT_GEN_READ    = 31;

   typedef enum logic [1:0] {
      KIND_ALLOC  = 2'd0,
      KIND_FREE   = 2'd1,
      KIND_LOOKUP = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_DENIED  = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CHECK_EN   = 3'd0,
      CSR_READ_MAP   = 3'd1,
      CSR_WRITE_MAP  = 3'd2,
      CSR_ALL_MAP    = 3'd3,
      CSR_THREAD_OBJ = 3'd4,
      CSR_PROC_OBJ   = 3'd5
   } csr_index_type;

   typedef struct packed {
      kind_type                kind;
      logic                    pseudo_thread;
      logic                    pseudo_process;
      logic                    form_ok;
      logic [SLOT_BITS-1:0]    slot;
      logic [OBJECT_W-1:0]     object_id;
      logic [MASK_W-1:0]       rights_mask;
   } item_type;

   typedef struct packed {
      logic not_empty;
      logic not_full;
   } queue_status_type;

   typedef struct packed {
      logic [OBJECT_ID_BITS-1:0] object_id;
      logic [MASK_W-1:0]         rights;
   } slot_entry_type;

   function automatic logic [OBJECT_ID_BITS-1:0] obj_store(input logic [OBJECT_W-1:0] v);
      logic [OBJECT_ID_BITS-1:0] r;
      r = '0;
      for (int i = 0; i < OBJECT_ID_BITS; i++) begin
         if (i < OBJECT_W) r[i] = v[i];
      end
      return r;
   endfunction

   function automatic logic [OBJECT_W-1:0] obj_load(input logic [OBJECT_ID_BITS-1:0] v);
      logic [OBJECT_W-1:0] r;
      r = '0;
      for (int i = 0; i < OBJECT_W; i++) begin
         if (i < OBJECT_ID_BITS) r[i] = v[i];
      end
      return r;
   endfunction

endpackage

>>> rtl/handle_table_engine_core.sv
// Handle table engine: a taken request waits in the queue, is registered into
// the back end with its slot entry, and has its result registered for output.
// The back end takes one request at a time, reading slot memory when idle and
// executing in its exec state. Synchronous reset empties the table, zeroes the
// CSRs, and leaves slot memory uncleared; no clearing pass runs after reset.
// Depends on htbl_pkg, htbl_front, htbl_queue and htbl_back.

module handle_table_engine_core
   import htbl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // handle_in[31:0], object_id[47:32], rights_mask[79:48]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // status[1:0], handle_out[33:2], object_out[49:34], zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   queue_status_type q_status;
   item_type         push_item, head_item;
   logic             q_push, q_pop;

   htbl_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   htbl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head_item (head_item),
      .status    (q_status)
   );

   htbl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .q_status   (q_status),
      .q_item     (head_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> rtl/htbl_queue.sv
// Short request queue between the front decoder and the back executor.
// Depends on htbl_pkg for the item type and queue depth.

module htbl_queue
   import htbl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  item_type         push_item,
   input  logic             pop,
   output item_type         head_item,
   output queue_status_type status
);

   item_type               entry_ff [QDEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign status.not_empty = (count_ff != '0);
   assign status.not_full  = (count_ff != QCNT_BITS'(QDEPTH));
   assign do_push = push && status.not_full;
   assign do_pop  = pop && status.not_empty;
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_BITS'(do_push) - QCNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_item;
   end

endmodule

>>> rtl/htbl_front.sv
// Front end: accepts requests, classifies the handle and forms a queue item.
// Depends on htbl_pkg for the item type and handle constants.

module htbl_front
   import htbl_pkg::*;
(
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]            req_tuser,
   input  queue_status_type      q_status,
   output logic                  q_push,
   output item_type              q_item
);

   logic [HANDLE_W-1:0] handle;
   logic [HANDLE_W-3:0] slot_num;

   assign handle     = req_tdata[HANDLE_W-1:0];
   assign slot_num   = handle[HANDLE_W-1:2] - (HANDLE_W-2)'(1);
   assign req_tready = q_status.not_full;
   assign q_push     = req_tvalid && q_status.not_full;

   always_comb begin
      q_item.kind           = kind_type'(req_tuser);
      q_item.pseudo_thread  = (handle == PSEUDO_THREAD);
      q_item.pseudo_process = (handle == PSEUDO_PROCESS);
      q_item.form_ok        = (handle[HANDLE_W-1:2] != '0) && (handle[1:0] == 2'b00)
                              && (slot_num < (HANDLE_W-2)'(SLOT_COUNT));
      q_item.slot           = slot_num[SLOT_BITS-1:0];
      q_item.object_id      = req_tdata[HANDLE_W +: OBJECT_W];
      q_item.rights_mask    = req_tdata[HANDLE_W+OBJECT_W +: MASK_W];
   end

endmodule

>>> rtl/htbl_back.sv
// Back end: slot table, configuration registers and the result register.
// Depends on htbl_pkg; takes items from htbl_queue one at a time.

module htbl_back
   import htbl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  queue_status_type      q_status,
   input  item_type              q_item,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   typedef enum logic [1:0] {
      BK_IDLE = 2'b01,
      BK_EXEC = 2'b10
   } back_state_type;

   back_state_type            state_ff, state_in;
   item_type                  item_ff;
   slot_entry_type            mem [SLOT_COUNT];
   slot_entry_type            rd_entry_ff;
   logic [SLOT_COUNT-1:0]     used_ff, used_in;

   logic                      check_en_ff;
   logic [MASK_W-1:0]         read_map_ff, write_map_ff, all_map_ff;
   logic [OBJECT_W-1:0]       thread_obj_ff, proc_obj_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;

   logic                      out_free, finish, any_free, slot_hit, denied, mem_we;
   logic [SLOT_BITS-1:0]      free_slot;
   logic [MASK_W-1:0]         eff_rights, granted;
   status_type                status;
   logic [HANDLE_W-1:0]       handle_out;
   logic [OBJECT_W-1:0]       object_out;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign q_pop      = (state_ff == BK_IDLE) && q_status.not_empty;
   assign finish     = (state_ff == BK_EXEC) && out_free;

   always_comb begin
      any_free  = 1'b0;
      free_slot = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            any_free  = 1'b1;
            free_slot = SLOT_BITS'(i);
         end
      end
   end

   assign granted  = rd_entry_ff.rights;
   assign slot_hit = item_ff.form_ok && used_ff[item_ff.slot];

   always_comb begin
      eff_rights = {{(MASK_W-LOW_RIGHTS_W){1'b0}}, granted[LOW_RIGHTS_W-1:0]};
      if (granted[BIT_MAX_ALLOWED] || granted[BIT_GEN_ALL]) eff_rights = eff_rights | all_map_ff;
      if (granted[BIT_GEN_READ])  eff_rights = eff_rights | read_map_ff;
      if (granted[BIT_GEN_WRITE]) eff_rights = eff_rights | write_map_ff;
   end

   assign denied = check_en_ff && ((item_ff.rights_mask & ~eff_rights) != '0);

   always_comb begin
      status     = ST_OK;
      handle_out = '0;
      object_out = '0;
      used_in    = used_ff;
      mem_we     = 1'b0;
      unique case (item_ff.kind)
         KIND_ALLOC: begin
            if (any_free) begin
               handle_out = HANDLE_W'({1'b0, free_slot} + (SLOT_BITS+1)'(1)) << 2;
               used_in[free_slot] = 1'b1;
               mem_we = 1'b1;
            end else begin
               status = ST_FULL;
            end
         end
         KIND_FREE: begin
            if (slot_hit) used_in[item_ff.slot] = 1'b0;
            else status = ST_INVALID;
         end
         KIND_LOOKUP: begin
            priority if (item_ff.pseudo_thread) begin
               object_out = thread_obj_ff;
            end else if (item_ff.pseudo_process) begin
               object_out = proc_obj_ff;
            end else if (!slot_hit) begin
               status = ST_INVALID;
            end else if (denied) begin
               status = ST_DENIED;
            end else begin
               object_out = obj_load(rd_entry_ff.object_id);
            end
         end
         KIND_CLEAR: begin
            used_in = '0;
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_status.not_empty) state_in = BK_EXEC;
         end
         BK_EXEC: begin
            if (out_free) begin
               state_in     = BK_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(RSP_DATA_W-2-HANDLE_W-OBJECT_W){1'b0}},
                               object_out, handle_out, status};
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (finish) used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (q_pop) item_ff <= q_item;
   end

   always_ff @(posedge clock) begin
      if (finish && mem_we) mem[free_slot] <= '{obj_store(item_ff.object_id),
                                                 item_ff.rights_mask};
      if (q_pop) rd_entry_ff <= mem[q_item.slot];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         check_en_ff   <= 1'b0;
         read_map_ff   <= '0;
         write_map_ff  <= '0;
         all_map_ff    <= '0;
         thread_obj_ff <= '0;
         proc_obj_ff   <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CHECK_EN:   check_en_ff   <= csr_data[0];
            CSR_READ_MAP:   read_map_ff   <= csr_data;
            CSR_WRITE_MAP:  write_map_ff  <= csr_data;
            CSR_ALL_MAP:    all_map_ff    <= csr_data;
            CSR_THREAD_OBJ: thread_obj_ff <= csr_data[OBJECT_W-1:0];
            CSR_PROC_OBJ:   proc_obj_ff   <= csr_data[OBJECT_W-1:0];
            default: ;
         endcase
      end
   end

endmodule

>>> rtl/htbl_checker.sv
// Port-level checker for the handle table engine, bound to the top level.
// Depends on htbl_pkg for status codes and port widths.

module htbl_checker
   import htbl_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [1:0]          rsp_status;
   logic [HANDLE_W-1:0] rsp_handle;
   logic [OBJECT_W-1:0] rsp_object;

   assign rsp_status = rsp_tdata[1:0];
   assign rsp_handle = rsp_tdata[2 +: HANDLE_W];
   assign rsp_object = rsp_tdata[2+HANDLE_W +: OBJECT_W];

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status != ST_OK |-> rsp_handle == '0 && rsp_object == '0)
      else $error("failed request carries data");

   a_alloc_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_handle != '0 |->
         rsp_status == ST_OK && rsp_handle[1:0] == 2'b00 && rsp_object == '0)
      else $error("malformed allocate response");

endmodule

bind handle_table_engine_core htbl_checker u_checker (.*);

>>> verif/handle_table_checker.sv
`timescale 1ns / 100ps
// Checker for handle_table_engine_core: follows the request, response and register
// channels, predicts every response from its own copy of the table, and compares.
// Depends on htbl_pkg.

module handle_table_checker
   import htbl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]            req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    fault_count,
   output int                    awaited_count
);

   typedef struct packed {
      status_type          status;
      logic [HANDLE_W-1:0] handle_out;
      logic [OBJECT_W-1:0] object_out;
   } response_type;

   localparam int REPORT_CAP = 40;

   response_type awaited_q[$];
   int faults = 0;
   int awaited_n = 0;

   logic                      check_en;
   logic [MASK_W-1:0]         read_map;
   logic [MASK_W-1:0]         write_map;
   logic [MASK_W-1:0]         all_map;
   logic [OBJECT_W-1:0]       thread_obj;
   logic [OBJECT_W-1:0]       process_obj;
   logic                      slot_used [SLOT_COUNT];
   logic [OBJECT_ID_BITS-1:0] slot_obj [SLOT_COUNT];
   logic [MASK_W-1:0]         slot_rights [SLOT_COUNT];

   assign fault_count   = faults;
   assign awaited_count = awaited_n;

   task automatic report_mismatch(input string what, input logic [HANDLE_W-1:0] got,
                                  input logic [HANDLE_W-1:0] want);
      if (faults < REPORT_CAP) begin
         $display("%0t: %s: got %h, expected %h", $time, what, got, want);
      end
      faults++;
   endtask

   function automatic bit find_slot(input logic [HANDLE_W-1:0] h, output int idx);
      logic [HANDLE_W-1:0] n;
      idx = 0;
      n = (h >> 2) - 1;
      if (h == '0 || h[1:0] != 2'b00 || n >= SLOT_COUNT) return 1'b0;
      if (!slot_used[n]) return 1'b0;
      idx = int'(n);
      return 1'b1;
   endfunction

   function automatic response_type predict_response(input kind_type kind,
                                                     input logic [HANDLE_W-1:0] h,
                                                     input logic [OBJECT_W-1:0] obj,
                                                     input logic [MASK_W-1:0] mask);
      response_type r;
      logic [MASK_W-1:0] granted;
      logic [MASK_W-1:0] eff;
      int idx;
      r = '0;
      r.status = ST_OK;
      case (kind)
         KIND_ALLOC: begin
            r.status = ST_FULL;
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (!slot_used[i]) begin
                  slot_used[i] = 1'b1;
                  slot_obj[i] = obj[OBJECT_ID_BITS-1:0];
                  slot_rights[i] = mask;
                  r.handle_out = HANDLE_W'((i + 1) * 4);
                  r.status = ST_OK;
                  break;
               end
            end
         end
         KIND_FREE: begin
            if (find_slot(h, idx)) begin
               slot_used[idx] = 1'b0;
               slot_obj[idx] = '0;
               slot_rights[idx] = '0;
            end else begin
               r.status = ST_INVALID;
            end
         end
         KIND_LOOKUP: begin
            if (h == PSEUDO_THREAD) begin
               r.object_out = thread_obj;
            end else if (h == PSEUDO_PROCESS) begin
               r.object_out = process_obj;
            end else if (!find_slot(h, idx)) begin
               r.status = ST_INVALID;
            end else begin
               granted = slot_rights[idx];
               eff = '0;
               eff[LOW_RIGHTS_W-1:0] = granted[LOW_RIGHTS_W-1:0];
               if (granted[BIT_MAX_ALLOWED] || granted[BIT_GEN_ALL]) eff |= all_map;
               if (granted[BIT_GEN_READ]) eff |= read_map;
               if (granted[BIT_GEN_WRITE]) eff |= write_map;
               if (check_en && (mask & ~eff) != '0) begin
                  r.status = ST_DENIED;
               end else begin
                  r.object_out = OBJECT_W'(slot_obj[idx]);
               end
            end
         end
         default: begin
            for (int i = 0; i < SLOT_COUNT; i++) slot_used[i] = 1'b0;
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      response_type got;
      response_type want;
      if (reset) begin
         check_en = 1'b0;
         read_map = '0;
         write_map = '0;
         all_map = '0;
         thread_obj = '0;
         process_obj = '0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_used[i] = 1'b0;
            slot_obj[i] = '0;
            slot_rights[i] = '0;
         end
         awaited_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CHECK_EN:   check_en = csr_data[0];
               CSR_READ_MAP:   read_map = csr_data;
               CSR_WRITE_MAP:  write_map = csr_data;
               CSR_ALL_MAP:    all_map = csr_data;
               CSR_THREAD_OBJ: thread_obj = csr_data[OBJECT_W-1:0];
               CSR_PROC_OBJ:   process_obj = csr_data[OBJECT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status = status_type'(rsp_tdata[1:0]);
            got.handle_out = rsp_tdata[2 +: HANDLE_W];
            got.object_out = rsp_tdata[2 + HANDLE_W +: OBJECT_W];
            if (awaited_q.size() == 0) begin
               report_mismatch("response with no request waiting", got.handle_out, '0);
            end else begin
               want = awaited_q.pop_front();
               if (got.status !== want.status)
                  report_mismatch("status", HANDLE_W'(got.status), HANDLE_W'(want.status));
               if (got.handle_out !== want.handle_out)
                  report_mismatch("handle_out", got.handle_out, want.handle_out);
               if (got.object_out !== want.object_out)
                  report_mismatch("object_out", HANDLE_W'(got.object_out),
                                  HANDLE_W'(want.object_out));
            end
         end
         if (req_tvalid && req_tready) begin
            awaited_q.push_back(predict_response(kind_type'(req_tuser),
                                                 req_tdata[HANDLE_W-1:0],
                                                 req_tdata[HANDLE_W +: OBJECT_W],
                                                 req_tdata[HANDLE_W + OBJECT_W +: MASK_W]));
         end
      end
      awaited_n = awaited_q.size();
   end

endmodule

>>> verif/handle_table_engine_core_test.sv
`timescale 1ns / 100ps
// Top of the handle table engine test: drives requests and register writes, stalls
// both channels at random, and gives the verdict from the checker's fault count.
// Depends on htbl_pkg, handle_table_engine_core and handle_table_checker.

module handle_table_engine_core_test;
   import htbl_pkg::*;

   localparam int PHASE_COUNT   = 5;
   localparam int PHASE_ITEMS   = 230;
   localparam int SETTLE_CYCLES = 4;
   localparam int IDLE_PCT      = 36;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam logic [MASK_W-1:0] GENERIC_BITS = (32'd1 << BIT_GEN_READ) |
      (32'd1 << BIT_GEN_WRITE) | (32'd1 << BIT_GEN_ALL) | (32'd1 << BIT_MAX_ALLOWED);

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [1:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   logic                  steady = 1'b0;
   int                    fault_count;
   int                    awaited_count;

   always #10 clock = ~clock;

   always @(negedge clock) rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

   handle_table_engine_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   handle_table_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fault_count   (fault_count),
      .awaited_count (awaited_count)
   );

   // hold the write until taken; valid stays high for a following write
   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic set_registers(input logic en, input logic [MASK_W-1:0] rmap,
                                input logic [MASK_W-1:0] wmap, input logic [MASK_W-1:0] amap,
                                input logic [OBJECT_W-1:0] tobj,
                                input logic [OBJECT_W-1:0] pobj);
      logic [CSR_DATA_W-1:0] v;
      write_register(CSR_SPARE_LO, $urandom);
      write_register(CSR_SPARE_HI, $urandom);
      v = $urandom;
      v[0] = en;
      write_register(CSR_CHECK_EN, v);
      write_register(CSR_READ_MAP, rmap);
      write_register(CSR_WRITE_MAP, wmap);
      write_register(CSR_ALL_MAP, amap);
      v = $urandom;
      v[OBJECT_W-1:0] = tobj;
      write_register(CSR_THREAD_OBJ, v);
      v = $urandom;
      v[OBJECT_W-1:0] = pobj;
      write_register(CSR_PROC_OBJ, v);
      csr_valid <= 1'b0;
   endtask

   // hold the request until taken; valid stays high unless a gap follows
   task automatic send_request(input kind_type kind, input logic [HANDLE_W-1:0] h,
                               input logic [OBJECT_W-1:0] obj,
                               input logic [MASK_W-1:0] mask);
      if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < IDLE_PCT);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {mask, obj, h};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain_requests();
      req_tvalid <= 1'b0;
      while (awaited_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [HANDLE_W-1:0] pick_handle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return HANDLE_W'(($urandom_range(0, SLOT_COUNT - 1) + 1) * 4);
      if (r < 70) return PSEUDO_THREAD;
      if (r < 75) return PSEUDO_PROCESS;
      if (r < 80) return '0;
      if (r < 85) return HANDLE_W'(($urandom_range(SLOT_COUNT, SLOT_COUNT + 8) + 1) * 4);
      return $urandom;
   endfunction

   task automatic run_phase(input int items, input int alloc_pct, input int free_pct,
                            input int clear_pct);
      int r;
      logic [MASK_W-1:0] m;
      for (int n = 0; n < items; n++) begin
         r = $urandom_range(0, 99);
         if (r < alloc_pct) begin
            case ($urandom_range(0, 3))
               0: m = $urandom;
               1: m = $urandom & 32'h00FF_FFFF;
               2: m = ($urandom & GENERIC_BITS) | ($urandom & 32'h0000_00FF);
               default: m = ($urandom_range(0, 1) == 0) ? '0 : '1;
            endcase
            send_request(KIND_ALLOC, $urandom, OBJECT_W'($urandom), m);
         end else if (r < alloc_pct + free_pct) begin
            send_request(KIND_FREE, pick_handle(), OBJECT_W'($urandom), $urandom);
         end else if (r < alloc_pct + free_pct + clear_pct) begin
            send_request(KIND_CLEAR, pick_handle(), OBJECT_W'($urandom), $urandom);
         end else begin
            case ($urandom_range(0, 3))
               0: m = '0;
               1: m = $urandom & $urandom & 32'h00FF_FFFF;
               2: m = 32'd1 << $urandom_range(0, 31);
               default: m = $urandom;
            endcase
            send_request(KIND_LOOKUP, pick_handle(), OBJECT_W'($urandom), m);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = KIND_ALLOC;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      set_registers(1'b1, '1, '0, 32'h0F0F_F0F0, 16'hFFFF, 16'h0000);
      send_request(KIND_LOOKUP, PSEUDO_THREAD, 16'h0000, '1);
      send_request(KIND_LOOKUP, PSEUDO_PROCESS, 16'hFFFF, '1);
      send_request(KIND_FREE, PSEUDO_THREAD, 16'h0000, '0);
      send_request(KIND_FREE, PSEUDO_PROCESS, 16'h0000, '0);
      send_request(KIND_LOOKUP, '0, 16'h0000, '0);
      send_request(KIND_FREE, '0, 16'h0000, '0);
      send_request(KIND_LOOKUP, 32'd4, 16'h0000, '0);
      send_request(KIND_ALLOC, '1, 16'hFFFF, '1);
      send_request(KIND_ALLOC, '0, 16'h0000, '0);
      send_request(KIND_ALLOC, '0, 16'h1234, 32'h8000_0000);
      send_request(KIND_ALLOC, '0, 16'h5A5A, 32'h0000_00FF);
      send_request(KIND_LOOKUP, 32'd4, 16'h0000, '1);
      send_request(KIND_LOOKUP, 32'd8, 16'h0000, '0);
      send_request(KIND_LOOKUP, 32'd8, 16'h0000, 32'h0000_0001);
      send_request(KIND_LOOKUP, 32'd12, 16'h0000, '1);
      send_request(KIND_LOOKUP, 32'd16, 16'h0000, 32'h0000_0100);
      send_request(KIND_LOOKUP, 32'd6, 16'h0000, '0);
      send_request(KIND_LOOKUP, HANDLE_W'((SLOT_COUNT + 1) * 4), 16'h0000, '0);
      send_request(KIND_FREE, 32'hFFFF_FFFC, 16'h0000, '0);
      send_request(KIND_FREE, 32'd8, 16'h0000, '0);
      send_request(KIND_LOOKUP, 32'd8, 16'h0000, '0);
      send_request(KIND_FREE, 32'd8, 16'h0000, '0);
      send_request(KIND_ALLOC, '0, 16'h00A5, 32'h4000_0000);
      send_request(KIND_CLEAR, '0, 16'h0000, '0);
      send_request(KIND_LOOKUP, 32'd4, 16'h0000, '0);
      drain_requests();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: set_registers(1'b1, $urandom, $urandom, $urandom, OBJECT_W'($urandom),
                             16'hFFFF);
            1: set_registers(1'b0, '1, '1, '1, 16'hFFFF, 16'hFFFF);
            2: set_registers(1'b1, '0, '0, '0, '0, '0);
            default: set_registers(1'b1, $urandom & $urandom, $urandom, $urandom | $urandom,
                                   OBJECT_W'($urandom), OBJECT_W'($urandom));
         endcase
         steady <= (p == 1);
         if (p == 0) run_phase(PHASE_ITEMS, 75, 10, 0);
         else run_phase(PHASE_ITEMS, 40, 30, 2);
         drain_requests();
      end

      if (fault_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("tb: failure");
      $finish;
   end

endmodule

>>> filelist.f
rtl/htbl_pkg.sv
rtl/htbl_queue.sv
rtl/htbl_front.sv
rtl/htbl_back.sv
rtl/handle_table_engine_core.sv
rtl/htbl_checker.sv
verif/handle_table_checker.sv
verif/handle_table_engine_core_test.sv
